>>> hdl/fdt_pkg.sv
// ----------------------------------------------------------------------------
// fdt_pkg
// Shared codes, register indexes and default sizes of the frame drop tracker.
// ----------------------------------------------------------------------------
package fdt_pkg;

    localparam int PENDING_DEPTH_DEF  = 64;
    localparam int RENDERED_DEPTH_DEF = 64;
    localparam int TIME_BITS_DEF      = 63;

    localparam int MAXP_BITS  = 6;
    localparam int SKEW_BITS  = 20;
    localparam int COUNT_BITS = 32;
    localparam int PCNT_BITS  = 7;

    localparam logic [MAXP_BITS-1:0] MAXP_RESET = 6'd63;
    localparam logic [SKEW_BITS-1:0] SKEW_RESET = 20'd5000;

    typedef logic [1:0] t_op;
    localparam t_op OP_QUEUE  = 2'd0;
    localparam t_op OP_REND   = 2'd1;
    localparam t_op OP_SEEK   = 2'd2;
    localparam t_op OP_UPDATE = 2'd3;

    localparam logic CFG_MAX_PENDING = 1'b0;
    localparam logic CFG_SKEW_LIMIT  = 1'b1;

endpackage

>>> hdl/frame_drop_tracker.sv
// One item is worked on at a time; each step is a RAM read (registered read data) and
// a compare. A queued item walks the pending entries newer than it; an update or seek
// purges pending entries below the seek point, then walks the rendered entries and the
// matched pending entries. A stalled result holds the block in its finish step.
// Reset (synchronous, active low) empties both stores by clearing fill counts.
// ----------------------------------------------------------------------------
// frame_drop_tracker
// Sorted pending timestamp store in a circular RAM, rendered store in a RAM,
// matching walk on update or seek that counts dropped frames.
// ----------------------------------------------------------------------------
module frame_drop_tracker
    import fdt_pkg::*;
#(
    parameter int PENDING_DEPTH  = PENDING_DEPTH_DEF,
    parameter int RENDERED_DEPTH = RENDERED_DEPTH_DEF,
    parameter int TIME_BITS      = TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_operation,
    input  logic [TIME_BITS-1:0]  i_time_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [COUNT_BITS-1:0] o_dropped_count,
    output logic [PCNT_BITS-1:0]  o_pending_count,
    output logic                  o_duplicate_flag,
    output logic                  o_overflow_flag,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [SKEW_BITS-1:0]  i_cfg_data
);

    localparam int PA  = $clog2(PENDING_DEPTH);
    localparam int PFW = $clog2(PENDING_DEPTH + 1);
    localparam int SW  = PFW + 1;
    localparam int RA  = $clog2(RENDERED_DEPTH);
    localparam int RFW = $clog2(RENDERED_DEPTH + 1);
    localparam int TW1 = TIME_BITS + 1;

    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_Q_START  = 5'd1;
    localparam logic [4:0] ST_Q_SC_RD  = 5'd2;
    localparam logic [4:0] ST_Q_SC_EX  = 5'd3;
    localparam logic [4:0] ST_Q_SH_RD  = 5'd4;
    localparam logic [4:0] ST_Q_SH_WR  = 5'd5;
    localparam logic [4:0] ST_REND     = 5'd6;
    localparam logic [4:0] ST_PURGE_RD = 5'd7;
    localparam logic [4:0] ST_PURGE_EX = 5'd8;
    localparam logic [4:0] ST_LAST_RD  = 5'd9;
    localparam logic [4:0] ST_LAST_EX  = 5'd10;
    localparam logic [4:0] ST_R_RD     = 5'd11;
    localparam logic [4:0] ST_R_EX     = 5'd12;
    localparam logic [4:0] ST_M_RD     = 5'd13;
    localparam logic [4:0] ST_M_EX     = 5'd14;
    localparam logic [4:0] ST_U_END    = 5'd15;
    localparam logic [4:0] ST_FIN      = 5'd16;

    logic [4:0]            r_state;
    t_op                   r_op;
    logic [TIME_BITS-1:0]  r_t;
    logic [MAXP_BITS-1:0]  r_max_pending;
    logic [SKEW_BITS-1:0]  r_skew;
    logic [PA-1:0]         r_head;
    logic [PFW-1:0]        r_fill;
    logic [PFW-1:0]        r_i;
    logic [PFW-1:0]        r_pos;
    logic [RFW-1:0]        r_rfill;
    logic [RFW-1:0]        r_k;
    logic [TIME_BITS-1:0]  r_seek;
    logic [TIME_BITS-1:0]  r_first;
    logic [TIME_BITS-1:0]  r_r;
    logic [TW1-1:0]        r_hi;
    logic [TW1-1:0]        r_top;
    logic [COUNT_BITS-1:0] r_dropped;
    logic                  r_dup;
    logic                  r_ovf;
    logic                  r_out_valid;
    logic [COUNT_BITS-1:0] r_out_dropped;
    logic [PCNT_BITS-1:0]  r_out_pcount;
    logic                  r_out_dup;
    logic                  r_out_ovf;

    logic                  p_we;
    logic [PA-1:0]         p_waddr;
    logic [PA-1:0]         p_raddr;
    logic [TIME_BITS-1:0]  p_wdata;
    logic [TIME_BITS-1:0]  p_rdata;
    logic                  q_we;
    logic [RA-1:0]         q_raddr;
    logic [TIME_BITS-1:0]  q_rdata;

    logic                  in_acc;
    logic                  out_load;
    logic                  evict;
    logic [TW1-1:0]        skew_w;
    logic [TW1-1:0]        p_w;
    logic [TW1-1:0]        q_w;
    logic [TW1-1:0]        q_top;

    // slot of the pending entry at offset off from the oldest one
    function automatic logic [PA-1:0] pidx(input logic [PA-1:0] head,
                                           input logic [PFW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(head) + SW'(off);
        if (s >= SW'(PENDING_DEPTH)) begin
            s = s - SW'(PENDING_DEPTH);
        end
        return s[PA-1:0];
    endfunction

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_load = (r_state == ST_FIN) && (!r_out_valid || i_out_ready);
    assign evict    = (32'(r_fill) > 32'(r_max_pending)) ||
                      (32'(r_fill) >= 32'(PENDING_DEPTH));
    assign skew_w   = TW1'(r_skew);
    assign p_w      = TW1'(p_rdata);
    assign q_w      = TW1'(q_rdata);
    assign q_top    = q_w + skew_w;

    always_comb begin
        p_we    = 1'b0;
        p_waddr = r_head;
        p_wdata = r_t;
        p_raddr = r_head;
        unique case (r_state)
            ST_Q_START: begin
                p_we = (r_fill == '0);
            end
            ST_Q_SC_RD: begin
                p_raddr = pidx(r_head, r_i - 1'b1);
            end
            ST_Q_SH_RD: begin
                if (r_i == r_pos) begin
                    p_we    = 1'b1;
                    p_waddr = pidx(r_head, r_i);
                end else begin
                    p_raddr = pidx(r_head, r_i - 1'b1);
                end
            end
            ST_Q_SH_WR: begin
                p_we    = 1'b1;
                p_waddr = pidx(r_head, r_i);
                p_wdata = p_rdata;
            end
            ST_LAST_RD: begin
                p_raddr = pidx(r_head, r_fill - 1'b1);
            end
            default: begin
                p_raddr = r_head;
            end
        endcase
    end

    assign q_we    = (r_state == ST_REND) && (r_rfill < RFW'(RENDERED_DEPTH));
    assign q_raddr = r_k[RA-1:0];

    fdt_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (PENDING_DEPTH)
    ) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    fdt_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (RENDERED_DEPTH)
    ) u_rend_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (r_rfill[RA-1:0]),
        .i_wdata (r_t),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_max_pending <= MAXP_RESET;
            r_skew        <= SKEW_RESET;
            r_head        <= '0;
            r_fill        <= '0;
            r_rfill       <= '0;
            r_seek        <= '0;
            r_dropped     <= '0;
            r_dup         <= 1'b0;
            r_ovf         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MAX_PENDING: r_max_pending <= i_cfg_data[MAXP_BITS-1:0];
                    CFG_SKEW_LIMIT:  r_skew        <= i_cfg_data;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_op  <= i_operation;
                        r_t   <= i_time_value;
                        r_dup <= 1'b0;
                        r_ovf <= 1'b0;
                        unique case (i_operation)
                            OP_QUEUE:            r_state <= ST_Q_START;
                            OP_REND:             r_state <= ST_REND;
                            OP_SEEK, OP_UPDATE:  r_state <= ST_PURGE_RD;
                        endcase
                    end
                end
                ST_Q_START: begin
                    if (r_fill == '0) begin
                        r_fill  <= PFW'(1);
                        r_state <= ST_FIN;
                    end else begin
                        // when over the limit or full, drop the oldest before placing the new one
                        if (evict) begin
                            r_head <= pidx(r_head, PFW'(1));
                            r_fill <= r_fill - 1'b1;
                            r_i    <= r_fill - 1'b1;
                        end else begin
                            r_i <= r_fill;
                        end
                        r_state <= ST_Q_SC_RD;
                    end
                end
                ST_Q_SC_RD: begin
                    if (r_i == '0) begin
                        r_pos   <= '0;
                        r_i     <= r_fill;
                        r_state <= ST_Q_SH_RD;
                    end else begin
                        r_state <= ST_Q_SC_EX;
                    end
                end
                ST_Q_SC_EX: begin
                    if (p_rdata < r_t) begin
                        r_pos   <= r_i;
                        r_i     <= r_fill;
                        r_state <= ST_Q_SH_RD;
                    end else if (p_rdata == r_t) begin
                        r_dup   <= 1'b1;
                        r_state <= ST_FIN;
                    end else begin
                        r_i     <= r_i - 1'b1;
                        r_state <= ST_Q_SC_RD;
                    end
                end
                ST_Q_SH_RD: begin
                    if (r_i == r_pos) begin
                        r_fill  <= r_fill + 1'b1;
                        r_state <= ST_FIN;
                    end else begin
                        r_state <= ST_Q_SH_WR;
                    end
                end
                ST_Q_SH_WR: begin
                    r_i     <= r_i - 1'b1;
                    r_state <= ST_Q_SH_RD;
                end
                ST_REND: begin
                    if (r_rfill < RFW'(RENDERED_DEPTH)) begin
                        r_rfill <= r_rfill + 1'b1;
                    end else begin
                        r_ovf <= 1'b1;
                    end
                    r_state <= ST_FIN;
                end
                ST_PURGE_RD: begin
                    r_state <= (r_fill == '0) ? ST_U_END : ST_PURGE_EX;
                end
                ST_PURGE_EX: begin
                    if (p_rdata < r_seek) begin
                        r_head  <= pidx(r_head, PFW'(1));
                        r_fill  <= r_fill - 1'b1;
                        r_state <= ST_PURGE_RD;
                    end else begin
                        r_first <= p_rdata;
                        r_state <= ST_LAST_RD;
                    end
                end
                ST_LAST_RD: begin
                    r_state <= ST_LAST_EX;
                end
                ST_LAST_EX: begin
                    r_hi    <= p_w + skew_w;
                    r_k     <= '0;
                    r_state <= ST_R_RD;
                end
                ST_R_RD: begin
                    r_state <= (r_k == r_rfill) ? ST_U_END : ST_R_EX;
                end
                ST_R_EX: begin
                    r_r   <= q_rdata;
                    r_top <= q_top;
                    r_k   <= r_k + 1'b1;
                    // keep only rendered entries inside the pending window
                    if (q_top >= TW1'(r_first) && q_w <= r_hi && r_fill != '0) begin
                        r_state <= ST_M_RD;
                    end else begin
                        r_state <= ST_R_RD;
                    end
                end
                ST_M_RD: begin
                    r_state <= (r_fill == '0) ? ST_R_RD : ST_M_EX;
                end
                ST_M_EX: begin
                    if (p_w <= r_top) begin
                        if ((p_w + skew_w) < TW1'(r_r) && r_dropped != '1) begin
                            r_dropped <= r_dropped + 1'b1;
                        end
                        r_head  <= pidx(r_head, PFW'(1));
                        r_fill  <= r_fill - 1'b1;
                        r_state <= ST_M_RD;
                    end else begin
                        r_state <= ST_R_RD;
                    end
                end
                ST_U_END: begin
                    r_rfill <= '0;
                    if (r_op == OP_SEEK) begin
                        r_fill <= '0;
                        r_seek <= r_t;
                    end
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // result payload, held while the consumer stalls
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_dropped <= r_dropped;
            r_out_pcount  <= PCNT_BITS'(r_fill);
            r_out_dup     <= r_dup;
            r_out_ovf     <= r_ovf;
        end
    end

    assign o_in_ready       = (r_state == ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_dropped_count  = r_out_dropped;
    assign o_pending_count  = r_out_pcount;
    assign o_duplicate_flag = r_out_dup;
    assign o_overflow_flag  = r_out_ovf;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= 32'(PENDING_DEPTH))
        else $error("pending fill above depth");

    a_rfill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_rfill) <= 32'(RENDERED_DEPTH))
        else $error("rendered fill above depth");

    a_update_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_U_END) |=> (r_rfill == '0))
        else $error("rendered store not emptied by update");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_FIN))
        else $error("result raised outside finish");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_dup && r_ovf))
        else $error("duplicate and overflow flags together");

endmodule

>>> hdl/fdt_ram.sv
// ----------------------------------------------------------------------------
// fdt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fdt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> tb/sv/tb_frame_drop_tracker.sv
// ----------------------------------------------------------------------------
// tb_frame_drop_tracker
// Drives queued, rendered, seek and update items into the frame drop tracker.
// A behavioral copy of the tracker predicts each result, and every result is
// compared with that prediction field by field. Both handshakes stall at
// random, and the configuration registers are swept between test phases.
// ----------------------------------------------------------------------------
module tb_frame_drop_tracker;
    import fdt_pkg::*;

    localparam int TB = TIME_BITS_DEF;
    localparam int PD = PENDING_DEPTH_DEF;
    localparam int RD = RENDERED_DEPTH_DEF;
    localparam logic [TB-1:0] TMAX = '1;
    localparam int IDLE_LIMIT = 20000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [1:0]            i_operation = OP_QUEUE;
    logic [TB-1:0]         i_time_value = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [COUNT_BITS-1:0] o_dropped_count;
    logic [PCNT_BITS-1:0]  o_pending_count;
    logic                  o_duplicate_flag;
    logic                  o_overflow_flag;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_index = CFG_MAX_PENDING;
    logic [SKEW_BITS-1:0]  i_cfg_data = '0;

    frame_drop_tracker dut (.*);

    always #10 i_clk = ~i_clk;

    typedef struct packed {
        logic [COUNT_BITS-1:0] dropped;
        logic [PCNT_BITS-1:0]  pending;
        logic                  dup;
        logic                  ovf;
    } t_result;

    // predictor state
    logic [TB-1:0]         pend_ts[$];
    logic [TB-1:0]         rend_ts[$];
    logic [TB-1:0]         seek_at;
    logic [COUNT_BITS-1:0] drop_total;
    logic [MAXP_BITS-1:0]  max_pend;
    logic [SKEW_BITS-1:0]  skew;

    t_result expected_results[$];
    int  fail_count = 0;
    int  idle_pct = 34;
    bit  hold_output = 0;

    function automatic logic [TB-1:0] add_sat(logic [TB-1:0] a, logic [SKEW_BITS-1:0] b);
        logic [TB:0] s;
        s = {1'b0, a} + b;
        return s[TB] ? TMAX : s[TB-1:0];
    endfunction

    function automatic void update_tracks();
        logic [TB-1:0] lo, hi, r;
        logic [TB-1:0] kept[$];
        while (pend_ts.size() > 0 && pend_ts[0] < seek_at) pend_ts.delete(0);
        if (pend_ts.size() == 0) begin
            rend_ts.delete();
            return;
        end
        lo = (pend_ts[0] >= skew) ? pend_ts[0] - skew : '0;
        hi = add_sat(pend_ts[$], skew);
        foreach (rend_ts[k]) begin
            if (rend_ts[k] >= lo && rend_ts[k] <= hi) kept.insert(kept.size(), rend_ts[k]);
        end
        foreach (kept[k]) begin
            r = kept[k];
            while (pend_ts.size() > 0 && pend_ts[0] <= add_sat(r, skew)) begin
                if (add_sat(pend_ts[0], skew) < r && drop_total != '1) drop_total++;
                pend_ts.delete(0);
            end
        end
        rend_ts.delete();
    endfunction

    function automatic t_result predict_item(t_op op, logic [TB-1:0] t);
        t_result res;
        int i;
        res = '0;
        case (op)
            OP_QUEUE: begin
                if (pend_ts.size() == 0) pend_ts.insert(0, t);
                else begin
                    if (pend_ts.size() > max_pend || pend_ts.size() >= PD)
                        pend_ts.delete(0);
                    i = pend_ts.size();
                    while (i > 0) begin
                        if (pend_ts[i-1] < t) break;
                        if (pend_ts[i-1] == t) begin
                            res.dup = 1'b1;
                            break;
                        end
                        i--;
                    end
                    if (!res.dup) pend_ts.insert(i, t);
                end
            end
            OP_REND: begin
                if (rend_ts.size() < RD) rend_ts.insert(rend_ts.size(), t);
                else res.ovf = 1'b1;
            end
            OP_SEEK: begin
                update_tracks();
                pend_ts.delete();
                seek_at = t;
            end
            default: update_tracks();
        endcase
        res.dropped = drop_total;
        res.pending = PCNT_BITS'(pend_ts.size());
        return res;
    endfunction

    // valid stays high between back-to-back items; drop it only to idle
    task automatic send_item(t_op op, logic [TB-1:0] t);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_time_value <= t;
        expected_results.insert(expected_results.size(), predict_item(op, t));
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [SKEW_BITS-1:0] val);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MAX_PENDING) max_pend = val[MAXP_BITS-1:0];
        else skew = val;
    endtask

    // keep timestamps near a base so matching and dropping happen
    function automatic logic [TB-1:0] near_time(logic [TB-1:0] base);
        return base + $urandom_range(40000);
    endfunction

    task automatic test_directed();
        send_item(OP_UPDATE, '0);              // update with nothing pending
        send_item(OP_QUEUE, TMAX);
        send_item(OP_QUEUE, TMAX);             // duplicate
        send_item(OP_QUEUE, '0);
        send_item(OP_QUEUE, 63'h2AAA_AAAA_AAAA_AAAA);
        send_item(OP_QUEUE, 63'h5555_5555_5555_5555);
        send_item(OP_REND, TMAX);              // high window edge saturates
        send_item(OP_REND, 63'd3);             // low window edge floors at 0
        send_item(OP_UPDATE, '0);
        send_item(OP_QUEUE, 63'd10000);
        send_item(OP_QUEUE, 63'd20000);
        send_item(OP_QUEUE, 63'd30000);
        send_item(OP_REND, 63'd29000);         // drops 10000 and 20000
        send_item(OP_UPDATE, '0);
        send_item(OP_SEEK, 63'd50000);
        send_item(OP_QUEUE, 63'd40000);
        send_item(OP_QUEUE, 63'd60000);
        send_item(OP_UPDATE, '0);              // purge below seek point
        for (int k = 0; k < 66; k++) send_item(OP_REND, 63'd60000 + k); // overflow
        send_item(OP_UPDATE, '0);
    endtask

    task automatic test_capacity();
        write_reg(CFG_MAX_PENDING, 20'd1);
        for (int k = 0; k < 6; k++) send_item(OP_QUEUE, 63'd100 * (6 - k));
        send_item(OP_QUEUE, 63'd100);          // eviction drops the first 100, so no duplicate
        write_reg(CFG_MAX_PENDING, 20'd63);
        for (int k = 0; k < 70; k++) send_item(OP_QUEUE, 63'd1000 + 3 * k);
        send_item(OP_REND, 63'd2000);
        send_item(OP_UPDATE, '0);
        send_item(OP_SEEK, '0);
    endtask

    task automatic run_random(int n, int seekish);
        logic [TB-1:0] base;
        base = TB'({$urandom, $urandom});
        for (int k = 0; k < n; k++) begin
            int sel;
            sel = $urandom_range(99);
            if ($urandom_range(99) < 3) base = TB'({$urandom, $urandom});
            if (sel < 50) send_item(OP_QUEUE, near_time(base));
            else if (sel < 80) send_item(OP_REND, near_time(base) + 20000);
            else if (sel < 80 + seekish) send_item(OP_SEEK, near_time(base));
            else if (sel < 97) send_item(OP_UPDATE, TB'({$urandom, $urandom}));
            else send_item(t_op'($urandom_range(3)), TB'({$urandom, $urandom}));
            if (sel > 90) base = base + $urandom_range(30000);
        end
    endtask

    task automatic test_random_sweep();
        write_reg(CFG_SKEW_LIMIT, '0);
        run_random(200, 3);
        write_reg(CFG_SKEW_LIMIT, 20'd1000000);
        write_reg(CFG_MAX_PENDING, 20'd7);
        run_random(250, 3);
        write_reg(CFG_SKEW_LIMIT, 20'($urandom_range(20000)));
        write_reg(CFG_MAX_PENDING, 20'($urandom_range(1, 63)));
        run_random(250, 4);
        write_reg(CFG_SKEW_LIMIT, 20'd5000);
        write_reg(CFG_MAX_PENDING, 20'd63);
        idle_pct = 0;                          // back-to-back stretch
        run_random(250, 2);
        idle_pct = 34;
    endtask

    task automatic test_backpressure();
        hold_output = 1;
        fork
            begin
                repeat (3000) @(posedge i_clk);
                hold_output = 0;
            end
            run_random(100, 3);
        join
        wait_drained();                        // sender pause until drained
        run_random(200, 3);
    endtask

    // result sink and checker
    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) i_out_ready <= 1'b0;
        else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result");
                    fail_count++;
                end else begin
                    exp_r = expected_results[0];
                    expected_results.delete(0);
                    if (o_dropped_count !== exp_r.dropped) begin
                        $error("dropped_count exp %0d got %0d", exp_r.dropped, o_dropped_count);
                        fail_count++;
                    end
                    if (o_pending_count !== exp_r.pending) begin
                        $error("pending_count exp %0d got %0d", exp_r.pending, o_pending_count);
                        fail_count++;
                    end
                    if (o_duplicate_flag !== exp_r.dup) begin
                        $error("duplicate_flag exp %0b got %0b", exp_r.dup, o_duplicate_flag);
                        fail_count++;
                    end
                    if (o_overflow_flag !== exp_r.ovf) begin
                        $error("overflow_flag exp %0b got %0b", exp_r.ovf, o_overflow_flag);
                        fail_count++;
                    end
                end
            end
            i_out_ready <= !hold_output && ($urandom_range(99) >= idle_pct);
        end
    end

    // watchdog: cycles with no item accepted on either side
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        pend_ts.delete();
        rend_ts.delete();
        seek_at    = '0;
        drop_total = '0;
        max_pend   = MAXP_RESET;
        skew       = SKEW_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_capacity();
        test_random_sweep();
        test_backpressure();
        wait_drained();
        repeat (400) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> frame_drop_tracker.f
hdl/fdt_pkg.sv
hdl/fdt_ram.sv
hdl/frame_drop_tracker.sv
tb/sv/tb_frame_drop_tracker.sv
